[hw/rtl/utf8cpe_pkg.sv]
// ----------------------------------------------------------------------------
// utf8cpe_pkg
// Shared constants and types for the UTF-8 code point end marker.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8cpe_pkg;

  localparam int unsigned HistDepth = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [HistDepth-1:0] hist_t;

  localparam byte_t PfxMin    = 8'hC0;
  localparam byte_t Lead2Lo   = 8'hC2;
  localparam byte_t Lead2Hi   = 8'hDF;
  localparam byte_t Lead3Lo   = 8'hE0;
  localparam byte_t Lead3Hi   = 8'hEF;
  localparam byte_t Lead4Lo   = 8'hF0;
  localparam byte_t Lead4Hi   = 8'hF4;
  localparam byte_t LeadE0    = 8'hE0;
  localparam byte_t LeadEd    = 8'hED;
  localparam byte_t LeadF0    = 8'hF0;
  localparam byte_t LeadF4    = 8'hF4;
  localparam byte_t SufLo     = 8'h80;
  localparam byte_t SufHi     = 8'hBF;
  localparam byte_t Suf8fHi   = 8'h8F;
  localparam byte_t Suf90Lo   = 8'h90;
  localparam byte_t Suf9fHi   = 8'h9F;
  localparam byte_t SufA0Lo   = 8'hA0;

  function automatic logic in_range(input byte_t b, input byte_t lo, input byte_t hi);
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_codepoint_end_marker.sv]
// ----------------------------------------------------------------------------
// utf8_codepoint_end_marker
// Marks the bytes of a UTF-8 stream that end a code point.
//
// Input channel (in_valid/in_ready): one stream byte per transfer plus a
// line-break flag that forces the byte final.
// Output channel (out_valid/out_ready): one is_final bit per input byte, in
// stream order.
// Results are registered. Throughput: one byte per cycle while in_ready is
// high; the classification is a set of range compares over the byte and a
// three-byte history register.
// Stall: a result register plus a one-entry skid register let the block take
// one more byte while a result waits; in_ready drops only while the skid
// register is occupied.
// Reset: the history is cleared to zero bytes (no open sequence) and both
// output stages are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_end_marker (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire utf8cpe_pkg::byte_t in_data_byte,
  input  wire                     in_line_break,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_is_final
);
  import utf8cpe_pkg::*;

  hist_t hist_r, hist_nxt;
  logic  out_valid_r, out_valid_nxt, out_final_r, out_final_nxt;
  logic  skid_valid_r, skid_valid_nxt, skid_final_r, skid_final_nxt;
  logic  in_fire, out_fire, cur_final;

  utf8cpe_classify u_classify (
    .cur_byte   (in_data_byte),
    .hist       (hist_r),
    .line_break (in_line_break),
    .is_final   (cur_final)
  );

  assign in_ready     = !skid_valid_r;
  assign out_valid    = out_valid_r;
  assign out_is_final = out_final_r;
  assign in_fire      = in_valid && in_ready;
  assign out_fire     = out_valid_r && out_ready;

  always_comb begin
    hist_nxt       = hist_r;
    out_valid_nxt  = out_valid_r;
    out_final_nxt  = out_final_r;
    skid_valid_nxt = skid_valid_r;
    skid_final_nxt = skid_final_r;
    if (in_fire) begin
      hist_nxt = {hist_r[HistDepth-2:0], in_data_byte};
    end
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_final_nxt  = skid_final_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_final_nxt = cur_final;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_final_nxt = cur_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      hist_r       <= hist_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_final_r  <= out_final_nxt;
    skid_final_r <= skid_final_nxt;
  end

  // skid stage is only ever filled behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register occupied while result register empty");

  // accepted byte enters the history
  a_hist_shift : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (hist_r[0] == $past(in_data_byte)))
    else $error("history did not take accepted byte");

  // a line break taken straight into the result register comes out final
  a_line_break_final : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_line_break && (out_fire || !out_valid_r)) |=> out_is_final)
    else $error("line break byte not marked final");

  // nothing is lost: a stalled result stays valid
  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_final_r)))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

[hw/rtl/utf8cpe_classify.sv]
// ----------------------------------------------------------------------------
// utf8cpe_classify
// Decides from the current byte and the three previous bytes whether the
// current byte ends a code point; invalid bytes always end their own unit.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cpe_classify (
  input  wire utf8cpe_pkg::byte_t cur_byte,
  input  wire utf8cpe_pkg::hist_t hist,
  input  wire                     line_break,
  output logic                    is_final
);
  import utf8cpe_pkg::*;

  byte_t p1, p2, p3;
  logic  is_pfx, legal_pfx, suffix, scope, non_final, bad_second, invalid;

  always_comb begin
    p1 = hist[0];
    p2 = hist[1];
    p3 = hist[2];

    is_pfx    = cur_byte >= PfxMin;
    legal_pfx = in_range(cur_byte, Lead2Lo, Lead2Hi) ||
                in_range(cur_byte, Lead3Lo, Lead3Hi) ||
                in_range(cur_byte, Lead4Lo, Lead4Hi);
    suffix    = in_range(cur_byte, SufLo, SufHi);

    scope = in_range(p1, Lead2Lo, Lead2Hi) || in_range(p1, Lead3Lo, Lead3Hi) ||
            in_range(p2, Lead3Lo, Lead3Hi) || in_range(p1, Lead4Lo, Lead4Hi) ||
            in_range(p2, Lead4Lo, Lead4Hi) || in_range(p3, Lead4Lo, Lead4Hi);

    non_final = is_pfx || in_range(p1, Lead3Lo, Lead3Hi) ||
                in_range(p1, Lead4Lo, Lead4Hi) || in_range(p2, Lead4Lo, Lead4Hi);

    bad_second = ((p1 == LeadE0) && in_range(cur_byte, SufLo, Suf9fHi)) ||
                 ((p1 == LeadEd) && in_range(cur_byte, SufA0Lo, SufHi)) ||
                 ((p1 == LeadF0) && in_range(cur_byte, SufLo, Suf8fHi)) ||
                 ((p1 == LeadF4) && in_range(cur_byte, Suf90Lo, SufHi));

    invalid  = (is_pfx != legal_pfx) || (scope != suffix) || bad_second;
    is_final = !(non_final && !invalid) || line_break;
  end

endmodule

`default_nettype wire
